/* design/sua_pkg.sv */
package sua_pkg;

	// Geometry of the unit space
	localparam int MAX_UNITS = 64;
	localparam int FRAMES    = 16;
	localparam int IDX_W     = 6;
	localparam int FRAME_W   = 4;
	localparam int UNIT_W    = FRAME_W + IDX_W;
	localparam int NUNITS    = FRAMES * MAX_UNITS;
	localparam int CNT_W     = 7;
	localparam int TOT_W     = 11;
	localparam int UW_W      = 13;
	localparam int LIM_W     = 11;

	// Item kinds
	localparam logic [1:0] K_ALLOC   = 2'd0;
	localparam logic [1:0] K_FREE    = 2'd1;
	localparam logic [1:0] K_RELEASE = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [1:0] ST_NO_FRAME = 2'd2;
	localparam logic [1:0] ST_NO_SLAB  = 2'd3;

	// Slab states
	localparam logic [1:0] SL_FREE     = 2'd0;
	localparam logic [1:0] SL_OCCUPIED = 2'd1;
	localparam logic [1:0] SL_VACANT   = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_UNIT_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SLAB_UNITS  = 2'd1;
	localparam logic [1:0] CFG_SPARE_LIMIT = 2'd2;

	typedef struct packed {
		logic [UW_W-1:0]  unit_width;
		logic [CNT_W-1:0] slab_units;
		logic [LIM_W-1:0] spare_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [15:0]       request_size;
		logic [UNIT_W-1:0] unit_handle;
		logic              handle_present;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [UNIT_W-1:0]  granted_unit;
		logic [UW_W-1:0]    granted_size;
		logic               slab_released;
		logic [FRAME_W-1:0] released_frame;
		logic [TOT_W-1:0]   vacant_total;
		logic [TOT_W-1:0]   occupied_total;
	} res_t;

endpackage

/* design/sua_ram.sv */
module sua_ram import sua_pkg::*; #(
	parameter int DEPTH = NUNITS,
	parameter int WIDTH = UNIT_W,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/sua_engine.sv */
module sua_engine import sua_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  start,
	input  item_t item,
	input  logic  out_free,
	output logic  busy,
	output logic  done,
	output res_t  res
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RM_WR  = 4'd1;
	localparam logic [3:0] S_FR_CHK = 4'd2;
	localparam logic [3:0] S_PA     = 4'd3;
	localparam logic [3:0] S_PB     = 4'd4;
	localparam logic [3:0] S_THR    = 4'd5;
	localparam logic [3:0] S_REL    = 4'd6;
	localparam logic [3:0] S_RL_RD  = 4'd7;
	localparam logic [3:0] S_RL_CHK = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0]         state_q;
	logic [UNIT_W-1:0]  handle_q;
	logic [UNIT_W-1:0]  cur_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FRAME_W-1:0] frame_q;
	logic               push_free_q;

	logic [UNIT_W-1:0]  head_q, tail_q;
	logic               hot_empty_q;
	logic [FRAME_W-1:0] vhead_q;
	logic               vac_empty_q;
	logic [FRAME_W-1:0] vnext_q [FRAMES];
	logic [FRAME_W-1:0] vprev_q [FRAMES];
	logic [CNT_W-1:0]   vcount_q [FRAMES];
	logic [CNT_W-1:0]   len_q [FRAMES];
	logic [1:0]         sstat_q [FRAMES];
	logic [TOT_W-1:0]   vacant_q, occupied_q;

	logic [1:0]         status_q;
	logic [UNIT_W-1:0]  granted_q;
	logic [UW_W-1:0]    gsize_q;
	logic               released_q;
	logic [FRAME_W-1:0] rframe_q;

	// Link memory ports
	logic              nx_we, pv_we, hot_we;
	logic [UNIT_W-1:0] nx_wa, pv_wa, hot_wa, rd_addr;
	logic [UNIT_W-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
	logic              hot_wd, hot_rd;

	// Derived values
	logic [CNT_W-1:0]   cur_units;
	logic               size_bad;
	logic               free_found;
	logic [FRAME_W-1:0] free_f;
	logic [FRAME_W-1:0] in_f, h_f, rel_f;
	logic               free_ok;
	logic [FRAME_W-1:0] vrm_f, vrm_n, vrm_p, vtail;
	logic               thr_hit;
	logic               rm_single;
	logic [CNT_W-1:0]   cnt_inc;

	function automatic logic [CNT_W-1:0] cnt_vac_next(input logic [UNIT_W-1:0] h);
		return vcount_q[h[UNIT_W-1:IDX_W]] + CNT_W'(1);
	endfunction

	assign cur_units = (cfg.slab_units == '0) ? CNT_W'(1) :
		(cfg.slab_units > CNT_W'(MAX_UNITS)) ? CNT_W'(MAX_UNITS) : cfg.slab_units;
	assign size_bad = (item.request_size == 16'd0) ||
		(item.request_size > {3'b0, cfg.unit_width});
	assign in_f  = item.unit_handle[UNIT_W-1:IDX_W];
	assign h_f   = head_q[UNIT_W-1:IDX_W];
	assign rel_f = vprev_q[vhead_q];
	assign free_ok = item.handle_present && (sstat_q[in_f] != SL_FREE) &&
		({1'b0, item.unit_handle[IDX_W-1:0]} < len_q[in_f]);
	assign vrm_f = (state_q == S_REL) ? rel_f : h_f;
	assign vrm_n = vnext_q[vrm_f];
	assign vrm_p = vprev_q[vrm_f];
	assign vtail = vprev_q[vhead_q];
	assign thr_hit = ({1'b0, vacant_q} >= ({1'b0, cfg.spare_limit} + {5'b0, cur_units}))
		&& !vac_empty_q;
	assign rm_single = (nx_rd == cur_q);
	assign cnt_inc = cnt_q + CNT_W'(1);

	// Lowest free frame
	always_comb begin
		free_found = 1'b0;
		free_f = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (sstat_q[i] == SL_FREE) begin
				free_found = 1'b1;
				free_f = FRAME_W'(i);
			end
		end
	end

	// Link memory control
	always_comb begin
		nx_we = 1'b0; nx_wa = cur_q; nx_wd = cur_q;
		pv_we = 1'b0; pv_wa = cur_q; pv_wd = cur_q;
		hot_we = 1'b0; hot_wa = cur_q; hot_wd = 1'b0;
		rd_addr = cur_q;
		case (state_q)
			S_IDLE: begin
				rd_addr = (item.kind == K_ALLOC) ? head_q : item.unit_handle;
				if (start && item.kind == K_ALLOC && !size_bad && hot_empty_q && free_found) begin
					hot_we = 1'b1;
					hot_wa = {free_f, IDX_W'(0)};
				end
			end
			S_PA: begin
				nx_we = 1'b1; nx_wd = hot_empty_q ? cur_q : head_q;
				pv_we = 1'b1; pv_wd = hot_empty_q ? cur_q : tail_q;
				hot_we = 1'b1; hot_wd = 1'b1;
			end
			S_PB: begin
				nx_we = 1'b1; nx_wa = tail_q;
				pv_we = 1'b1; pv_wa = head_q;
			end
			S_RM_WR, S_RL_CHK: begin
				if (state_q == S_RM_WR || hot_rd) begin
					hot_we = 1'b1;
					if (!rm_single) begin
						nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
						pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
					end
				end
			end
			default: begin
			end
		endcase
	end

	sua_ram #(.DEPTH(NUNITS), .WIDTH(UNIT_W)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(rd_addr), .rdata(nx_rd)
	);
	sua_ram #(.DEPTH(NUNITS), .WIDTH(UNIT_W)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(rd_addr), .rdata(pv_rd)
	);
	sua_ram #(.DEPTH(NUNITS), .WIDTH(1)) u_hot (
		.clk(clk), .we(hot_we), .waddr(hot_wa), .wdata(hot_wd), .raddr(rd_addr), .rdata(hot_rd)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hot_empty_q <= 1'b1;
			vac_empty_q <= 1'b1;
			vacant_q <= '0;
			occupied_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				sstat_q[i] <= SL_FREE;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						handle_q <= item.unit_handle;
						status_q <= ST_OK; granted_q <= '0; gsize_q <= '0;
						released_q <= 1'b0; rframe_q <= '0;
						state_q <= S_DONE;
						case (item.kind)
							K_ALLOC: begin
								if (size_bad) begin
									status_q <= ST_BAD_SIZE;
								end else if (!hot_empty_q) begin
									gsize_q <= cfg.unit_width;
									granted_q <= head_q;
									cur_q <= head_q;
									if (sstat_q[h_f] == SL_VACANT) begin
										sstat_q[h_f] <= SL_OCCUPIED;
										if (vrm_n == h_f) begin
											vac_empty_q <= 1'b1;
										end else begin
											vnext_q[vrm_p] <= vrm_n;
											vprev_q[vrm_n] <= vrm_p;
											if (vhead_q == h_f) vhead_q <= vrm_n;
										end
									end
									vcount_q[h_f] <= vcount_q[h_f] - CNT_W'(1);
									vacant_q <= vacant_q - TOT_W'(1);
									occupied_q <= occupied_q + TOT_W'(1);
									state_q <= S_RM_WR;
								end else if (!free_found) begin
									gsize_q <= cfg.unit_width;
									status_q <= ST_NO_FRAME;
								end else begin
									gsize_q <= cfg.unit_width;
									granted_q <= {free_f, IDX_W'(0)};
									sstat_q[free_f] <= SL_OCCUPIED;
									len_q[free_f] <= cur_units;
									vcount_q[free_f] <= cur_units - CNT_W'(1);
									vacant_q <= vacant_q + {4'b0, cur_units} - TOT_W'(1);
									occupied_q <= occupied_q + TOT_W'(1);
									frame_q <= free_f;
									cnt_q <= cur_units - CNT_W'(1);
									cur_q <= {free_f, IDX_W'(cur_units - CNT_W'(1))};
									push_free_q <= 1'b0;
									if (cur_units != CNT_W'(1)) state_q <= S_PA;
								end
							end
							K_FREE: begin
								if (free_ok) state_q <= S_FR_CHK;
							end
							K_RELEASE: state_q <= S_REL;
							default: begin
							end
						endcase
					end
				end
				S_RM_WR: begin
					if (rm_single) begin
						hot_empty_q <= 1'b1;
					end else begin
						if (head_q == cur_q) head_q <= nx_rd;
						if (tail_q == cur_q) tail_q <= pv_rd;
					end
					state_q <= S_DONE;
				end
				S_FR_CHK: begin
					if (hot_rd) begin
						state_q <= S_DONE;
					end else begin
						frame_q <= handle_q[UNIT_W-1:IDX_W];
						vcount_q[handle_q[UNIT_W-1:IDX_W]] <= cnt_vac_next(handle_q);
						vacant_q <= vacant_q + TOT_W'(1);
						occupied_q <= occupied_q - TOT_W'(1);
						if (cnt_vac_next(handle_q) == len_q[handle_q[UNIT_W-1:IDX_W]]) begin
							sstat_q[handle_q[UNIT_W-1:IDX_W]] <= SL_VACANT;
							vhead_q <= handle_q[UNIT_W-1:IDX_W];
							vac_empty_q <= 1'b0;
							if (vac_empty_q) begin
								vnext_q[handle_q[UNIT_W-1:IDX_W]] <= handle_q[UNIT_W-1:IDX_W];
								vprev_q[handle_q[UNIT_W-1:IDX_W]] <= handle_q[UNIT_W-1:IDX_W];
							end else begin
								vnext_q[handle_q[UNIT_W-1:IDX_W]] <= vhead_q;
								vprev_q[handle_q[UNIT_W-1:IDX_W]] <= vtail;
								vnext_q[vtail] <= handle_q[UNIT_W-1:IDX_W];
								vprev_q[vhead_q] <= handle_q[UNIT_W-1:IDX_W];
							end
						end
						cur_q <= handle_q;
						push_free_q <= 1'b1;
						state_q <= S_PA;
					end
				end
				S_PA, S_PB: begin
					if (state_q == S_PA && !hot_empty_q) begin
						state_q <= S_PB;
					end else begin
						head_q <= cur_q;
						if (state_q == S_PA) begin
							tail_q <= cur_q;
							hot_empty_q <= 1'b0;
						end
						if (push_free_q) begin
							state_q <= S_THR;
						end else if (cnt_q == CNT_W'(1)) begin
							state_q <= S_DONE;
						end else begin
							cnt_q <= cnt_q - CNT_W'(1);
							cur_q <= {frame_q, IDX_W'(cnt_q - CNT_W'(1))};
							state_q <= S_PA;
						end
					end
				end
				S_THR: begin
					state_q <= thr_hit ? S_REL : S_DONE;
				end
				S_REL: begin
					if (vac_empty_q) begin
						status_q <= ST_NO_SLAB;
						state_q <= S_DONE;
					end else begin
						if (vrm_n == rel_f) begin
							vac_empty_q <= 1'b1;
						end else begin
							vnext_q[vrm_p] <= vrm_n;
							vprev_q[vrm_n] <= vrm_p;
							if (vhead_q == rel_f) vhead_q <= vrm_n;
						end
						frame_q <= rel_f;
						vacant_q <= vacant_q - {4'b0, vcount_q[rel_f]};
						vcount_q[rel_f] <= '0;
						sstat_q[rel_f] <= SL_FREE;
						released_q <= 1'b1;
						rframe_q <= rel_f;
						cnt_q <= '0;
						cur_q <= {rel_f, IDX_W'(0)};
						state_q <= S_RL_RD;
					end
				end
				S_RL_RD: state_q <= S_RL_CHK;
				S_RL_CHK: begin
					if (hot_rd) begin
						if (rm_single) begin
							hot_empty_q <= 1'b1;
						end else begin
							if (head_q == cur_q) head_q <= nx_rd;
							if (tail_q == cur_q) tail_q <= pv_rd;
						end
					end
					if (cnt_inc == len_q[frame_q]) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_inc;
						cur_q <= {frame_q, IDX_W'(cnt_inc)};
						state_q <= S_RL_RD;
					end
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE) && out_free;
	assign res = '{status: status_q, granted_unit: granted_q, granted_size: gsize_q,
		slab_released: released_q, released_frame: rframe_q,
		vacant_total: vacant_q, occupied_total: occupied_q};

endmodule

/* design/slab_unit_allocator_core.sv */
// Slab unit allocator core.
// Input channel: in_valid/in_stall with kind, request_size, unit_handle and
// handle_present; a beat is taken when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall with one result beat per input beat.
// Configuration: cfg_valid/cfg_ready write port (cfg_index, cfg_data),
// always ready; write only while the block is idle.
// One item is worked at a time. A hot-list allocate unlinks the head unit;
// a free is ignored if the handle is bad or the unit hot, else pushes it,
// then releases a slab if vacant units reach the spare limit plus a slab;
// a new-slab claim pushes each unit but unit 0; a slab release reads and
// unlinks each hot unit of the slab. Each link memory has one write port.
// The next beat is taken once the result is loaded into the output register,
// so a waiting result does not block the following item's work beyond that.
// While out_stall is high the result register holds its beat; a finished
// item then waits in the core and in_stall stays high.
// Reset empties the hot and vacant lists, marks every frame free, zeroes
// the totals and loads the register defaults; link memories need no clearing.
module slab_unit_allocator_core import sua_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [UW_W-1:0]     cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [15:0]         request_size,
	input  logic [UNIT_W-1:0]   unit_handle,
	input  logic                handle_present,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [UNIT_W-1:0]   granted_unit,
	output logic [UW_W-1:0]     granted_size,
	output logic                slab_released,
	output logic [FRAME_W-1:0]  released_frame,
	output logic [TOT_W-1:0]    vacant_total,
	output logic [TOT_W-1:0]    occupied_total
);

	cfg_t  cfg_q;
	item_t item;
	res_t  res, res_q;
	logic  busy, done, out_free, start;
	logic  out_valid_q;

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit_width <= UW_W'(8);
			cfg_q.slab_units <= CNT_W'(64);
			cfg_q.spare_limit <= LIM_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_UNIT_WIDTH:  cfg_q.unit_width <= cfg_data;
				CFG_SLAB_UNITS:  cfg_q.slab_units <= cfg_data[CNT_W-1:0];
				CFG_SPARE_LIMIT: cfg_q.spare_limit <= cfg_data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign item = '{kind: kind, request_size: request_size,
		unit_handle: unit_handle, handle_present: handle_present};
	assign in_stall = busy;
	assign start = in_valid && !busy;
	assign out_free = !out_valid_q || !out_stall;

	sua_engine u_engine (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .start(start), .item(item),
		.out_free(out_free), .busy(busy), .done(done), .res(res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign granted_unit = res_q.granted_unit;
	assign granted_size = res_q.granted_size;
	assign slab_released = res_q.slab_released;
	assign released_frame = res_q.released_frame;
	assign vacant_total = res_q.vacant_total;
	assign occupied_total = res_q.occupied_total;

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> in_stall)
		else $error("core took a beat but did not go busy");

	a_done_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid)
		else $error("finished item not presented");

	a_units_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, res.vacant_total} + {1'b0, res.occupied_total}) <= 12'(NUNITS))
		else $error("unit totals exceed the unit space");

	a_no_done_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !done)
		else $error("result overwritten while stalled");

endmodule
